/* src/xml_name_validator_assert.svh */
// ----------------------------------------------------------------------------
// XML name validator assertion macros
// Concurrent checks clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef XML_NAME_VALIDATOR_ASSERT_SVH
`define XML_NAME_VALIDATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define XNV_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define XNV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/xnv_pkg.sv */
// ----------------------------------------------------------------------------
// XML name validator package
// Request and verdict types, codes and the reserved-prefix spelling.
// ----------------------------------------------------------------------------
package xnv_pkg;

	localparam int LENGTH_BITS_DEF = 16;

	localparam logic OP_CHAR = 1'b0;
	localparam logic OP_END  = 1'b1;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_EMPTY     = 3'd1,
		ERR_RESERVED  = 3'd2,
		ERR_BAD_START = 3'd3,
		ERR_BAD_CHAR  = 3'd4
	} err_code_t;

	typedef enum logic [1:0] {
		BR_NONE  = 2'd0,
		BR_NS    = 2'd1,
		BR_SHEET = 2'd2
	} prefix_branch_t;

	typedef struct packed {
		logic        opcode;
		logic [15:0] char_code;
	} req_t;

	typedef struct packed {
		logic        name_valid;
		logic [2:0]  error_code;
		logic [15:0] bad_position;
	} verdict_t;

	typedef struct packed {
		logic [15:0] folded;
		logic        start_ok;
		logic        name_ok;
	} char_class_t;

	// Spelling of "xml-stylesheet"; unused indexes read as zero.
	function automatic logic [15:0] sheet_char(input logic [3:0] idx);
		logic [15:0] c;
		unique case (idx)
			4'd0:    c = 16'h0078; // x
			4'd1:    c = 16'h006D; // m
			4'd2:    c = 16'h006C; // l
			4'd3:    c = 16'h002D; // -
			4'd4:    c = 16'h0073; // s
			4'd5:    c = 16'h0074; // t
			4'd6:    c = 16'h0079; // y
			4'd7:    c = 16'h006C; // l
			4'd8:    c = 16'h0065; // e
			4'd9:    c = 16'h0073; // s
			4'd10:   c = 16'h0068; // h
			4'd11:   c = 16'h0065; // e
			4'd12:   c = 16'h0065; // e
			4'd13:   c = 16'h0074; // t
			default: c = 16'h0000;
		endcase
		return c;
	endfunction

endpackage

/* src/xnv_char_class.sv */
// ----------------------------------------------------------------------------
// XML name validator character classifier
// Folds ASCII upper case and checks NameStartChar and NameChar ranges.
// ----------------------------------------------------------------------------
module xnv_char_class import xnv_pkg::*; (
	input  logic [15:0] char_code,
	output char_class_t cls
);

	logic [15:0] c;
	logic        start_ok;

	always_comb begin
		c = char_code;
		if (char_code >= 16'h0041 && char_code <= 16'h005A) begin
			c = char_code + 16'h0020;
		end
	end

	always_comb begin
		start_ok = (c == 16'h003A) || (c == 16'h005F) ||
			(c >= 16'h0041 && c <= 16'h005A) || (c >= 16'h0061 && c <= 16'h007A) ||
			(c >= 16'h00C0 && c <= 16'h00D6) || (c >= 16'h00D8 && c <= 16'h00F6) ||
			(c >= 16'h00F8 && c <= 16'h02FF) || (c >= 16'h0370 && c <= 16'h037D) ||
			(c >= 16'h037F && c <= 16'h1FFF) || (c >= 16'h200C && c <= 16'h200D) ||
			(c >= 16'h2070 && c <= 16'h218F) || (c >= 16'h2C00 && c <= 16'h2FEF) ||
			(c >= 16'h3001 && c <= 16'hD7FF) || (c >= 16'hF900 && c <= 16'hFDCF) ||
			(c >= 16'hFDF0 && c <= 16'hFFFD);
		cls.folded   = c;
		cls.start_ok = start_ok;
		cls.name_ok  = start_ok || (c == 16'h002D) || (c == 16'h002E) ||
			(c >= 16'h0030 && c <= 16'h0039) || (c == 16'h00B7) ||
			(c >= 16'h0300 && c <= 16'h036F) || (c >= 16'h203F && c <= 16'h2040);
	end

endmodule

/* src/xnv_tracker.sv */
// ----------------------------------------------------------------------------
// XML name validator name tracker
// Holds per-name state (length, reserved-prefix match, first error) and
// forms the verdict for the end-of-name request.
// ----------------------------------------------------------------------------
module xnv_tracker import xnv_pkg::*; #(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic        opcode,
	input  char_class_t cls,
	output verdict_t    verdict
);

	logic [LENGTH_BITS-1:0] len_q;
	logic [3:0]             prog_q;
	prefix_branch_t         branch_q;
	logic                   broken_q;
	err_code_t              bad_kind_q;
	logic [LENGTH_BITS-1:0] bad_idx_q;

	logic [3:0]     prog_d;
	prefix_branch_t branch_d;
	logic           broken_d;
	logic           complete;
	logic [15:0]    c;
	logic [32:0]    idx_ext;
	err_code_t      code;

	assign c        = cls.folded;
	assign complete = (branch_q == BR_NS && prog_q >= 4'd5) ||
		(branch_q == BR_SHEET && prog_q >= 4'd14);

	// Reserved-prefix matcher: stop once complete or broken.
	always_comb begin
		prog_d   = prog_q;
		branch_d = branch_q;
		broken_d = broken_q;
		if (!broken_q && !complete) begin
			if (prog_q < 4'd3) begin
				if (c == sheet_char(prog_q)) begin
					prog_d = prog_q + 4'd1;
				end else begin
					broken_d = 1'b1;
				end
			end else if (prog_q == 4'd3) begin
				if (c == 16'h006E) begin
					branch_d = BR_NS;
					prog_d   = 4'd4;
				end else if (c == 16'h002D) begin
					branch_d = BR_SHEET;
					prog_d   = 4'd4;
				end else begin
					broken_d = 1'b1;
				end
			end else if (branch_q == BR_NS) begin
				if (c == 16'h0073) begin
					prog_d = prog_q + 4'd1;
				end else begin
					broken_d = 1'b1;
				end
			end else begin
				if (c == sheet_char(prog_q)) begin
					prog_d = prog_q + 4'd1;
				end else begin
					broken_d = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			prog_q     <= '0;
			branch_q   <= BR_NONE;
			broken_q   <= 1'b0;
			bad_kind_q <= ERR_NONE;
			bad_idx_q  <= '0;
		end else if (step) begin
			if (opcode == OP_END) begin
				len_q      <= '0;
				prog_q     <= '0;
				branch_q   <= BR_NONE;
				broken_q   <= 1'b0;
				bad_kind_q <= ERR_NONE;
				bad_idx_q  <= '0;
			end else begin
				if (bad_kind_q == ERR_NONE) begin
					if (len_q == '0) begin
						if (!cls.start_ok) begin
							bad_kind_q <= ERR_BAD_START;
							bad_idx_q  <= '0;
						end
					end else if (!cls.name_ok) begin
						bad_kind_q <= ERR_BAD_CHAR;
						bad_idx_q  <= len_q;
					end
				end
				prog_q   <= prog_d;
				branch_q <= branch_d;
				broken_q <= broken_d;
				// saturate at all ones
				if (!(&len_q)) begin
					len_q <= len_q + LENGTH_BITS'(1);
				end
			end
		end
	end

	always_comb begin
		idx_ext = 33'(bad_idx_q);
		if (len_q == '0) begin
			code = ERR_EMPTY;
		end else if (prog_q >= 4'd3 && !(len_q == LENGTH_BITS'(3) || complete)) begin
			code = ERR_RESERVED;
		end else begin
			code = bad_kind_q;
		end
		verdict.name_valid   = (code == ERR_NONE);
		verdict.error_code   = code;
		verdict.bad_position = 16'h0000;
		if (code == ERR_BAD_START || code == ERR_BAD_CHAR) begin
			verdict.bad_position = (idx_ext > 33'h0FFFF) ? 16'hFFFF : idx_ext[15:0];
		end
	end

endmodule

/* src/xml_name_validator.sv */
// The verdict is registered after the end request leaves the input register.
// Throughput: one request per cycle, characters and end markers alike, while no stalled verdict holds back an end.
// A request is held in the input register, then updates the tracker
// or loads the verdict register; only a stalled verdict holds back an end.
// Reset (arst_n low, asynchronous) empties both registers and clears the
// per-name state.
// ----------------------------------------------------------------------------
// XML name validator
// Checks a UTF-16 name against the XML Name production, one unit per cycle unless a stalled verdict holds back an end.
// ----------------------------------------------------------------------------
module xml_name_validator import xnv_pkg::*; #(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_ready,
	input  req_t     item,
	output logic     verdict_valid,
	input  logic     verdict_ready,
	output verdict_t verdict
);

	logic        valid_s1;
	req_t        item_s1;
	logic        consume_s1;
	logic        end_s1;
	char_class_t cls;
	verdict_t    verdict_d;
	logic        verdict_valid_q;
	verdict_t    verdict_q;

	assign end_s1     = (item_s1.opcode == OP_END);
	assign consume_s1 = valid_s1 && (!end_s1 || !verdict_valid_q || verdict_ready);
	assign item_ready = !valid_s1 || consume_s1;

	xnv_char_class u_class (
		.char_code(item_s1.char_code),
		.cls      (cls)
	);

	xnv_tracker #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_tracker (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (consume_s1),
		.opcode (item_s1.opcode),
		.cls    (cls),
		.verdict(verdict_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verdict_valid_q <= 1'b0;
		end else if (consume_s1 && end_s1) begin
			verdict_valid_q <= 1'b1;
		end else if (verdict_ready) begin
			verdict_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume_s1 && end_s1) begin
			verdict_q <= verdict_d;
		end
	end

	assign verdict_valid = verdict_valid_q;
	assign verdict       = verdict_q;

`include "xml_name_validator_assert.svh"

	`XNV_ASSERT_NEXT(a_end_loads_verdict, consume_s1 && end_s1, verdict_valid_q, "end request did not load a verdict")
	`XNV_ASSERT_NOW(a_valid_matches_code, verdict_valid_q, verdict_q.name_valid == (verdict_q.error_code == ERR_NONE), "name_valid disagrees with error_code")
	`XNV_ASSERT_NOW(a_position_only_bad_char, verdict_valid_q && verdict_q.bad_position != 16'h0000, verdict_q.error_code == ERR_BAD_CHAR, "bad_position set without bad char")
	`XNV_ASSERT_NEXT(a_stall_holds_s1, valid_s1 && !item_ready, valid_s1 && $stable(item_s1), "stalled request lost in input register")

endmodule
